### sv/motor_run_mode_sequencer_unit_defines.svh
// ----------------------------------------------------------------------------
// Run mode sequencer assertion macros
// Shared property forms for the checker of the run mode sequencer.
// ----------------------------------------------------------------------------
`ifndef MOTOR_RUN_MODE_SEQUENCER_UNIT_DEFINES_SVH
`define MOTOR_RUN_MODE_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define MRMS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("run mode sequencer check failed");

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define MRMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("run mode sequencer check failed");

`endif

### sv/mrms_pkg.sv
// ----------------------------------------------------------------------------
// Run mode sequencer package
// Transfer types, configuration bundle and run mode codes.
// ----------------------------------------------------------------------------
package mrms_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Run mode codes as seen on the result channel.
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_PARAM   = 3'd1;
    localparam logic [2:0] MODE_PWMTEST = 3'd2;
    localparam logic [2:0] MODE_DEBUG   = 3'd3;
    localparam logic [2:0] MODE_OPEN    = 3'd4;
    localparam logic [2:0] MODE_CURRENT = 3'd5;
    localparam logic [2:0] MODE_SPEED   = 3'd6;
    localparam logic [2:0] MODE_FAULT   = 3'd7;

    typedef struct packed {
        logic enable_set;
        logic enable_clear;
        logic error_active;
        logic open_loop_done;
    } tick_t;

    typedef struct packed {
        logic [2:0]         run_state;
        logic               pwm_on;
        logic signed [15:0] q_reference;
        logic signed [15:0] q_voltage;
        logic               controller_init;
        logic               speed_init;
        logic               duty_apply;
    } result_t;

    typedef struct packed {
        logic [2:0]  run_target;
        logic        reverse_direction;
        logic [14:0] start_current;
        logic [14:0] run_current;
        logic [14:0] debug_current;
        logic [14:0] ramp_step;
        logic [15:0] dwell_ticks;
        logic [15:0] test_duty;
    } cfg_t;

endpackage

### sv/motor_run_mode_sequencer_unit.sv
// A tick taken into the tick register moves on into the result register when it advances.
// Throughput: one tick per cycle while result_stall is low; the tick register and result
// register each hold one item. One mode, ramp and dwell update between them sets that rate.
// Reset (rst_n low, asynchronous): mode idle, enable latch, PWM flag, Q values,
// dwell count and latched targets cleared; configuration registers take their defaults.
// ----------------------------------------------------------------------------
// Motor run mode sequencer
// Per-tick run mode state machine with Q reference and Q voltage ramps.
// ----------------------------------------------------------------------------
module motor_run_mode_sequencer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tick_valid,
    output logic                        tick_stall,
    input  mrms_pkg::tick_t             tick,
    output logic                        result_valid,
    input  logic                        result_stall,
    output mrms_pkg::result_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mrms_pkg::ADDR_W-1:0] paddr,
    input  logic [mrms_pkg::DATA_W-1:0] pwdata,
    output logic [mrms_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import mrms_pkg::*;

    cfg_t    cfg;
    tick_t   tick_reg;
    logic    tick_valid_reg, tick_valid_next;
    result_t result_reg;
    result_t result_next;
    logic    result_valid_reg, result_valid_next;
    logic    out_free;
    logic    advance;
    logic    take_tick;

    mrms_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The held tick moves on whenever the result register is empty or
    // being emptied in this cycle.
    assign out_free   = !result_valid_reg || !result_stall;
    assign advance    = tick_valid_reg && out_free;
    assign tick_stall = tick_valid_reg && !out_free;
    assign take_tick  = tick_valid && !tick_stall;

    assign tick_valid_next   = take_tick || (tick_valid_reg && !advance);
    assign result_valid_next = advance || (result_valid_reg && result_stall);

    mrms_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .tick        (tick_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            tick_valid_reg   <= tick_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_tick)
            tick_reg <= tick;
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### sv/mrms_regs.sv
// ----------------------------------------------------------------------------
// Run mode sequencer configuration registers
// APB-style register file holding the eight setup registers.
// ----------------------------------------------------------------------------
module mrms_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mrms_pkg::ADDR_W-1:0] paddr,
    input  logic [mrms_pkg::DATA_W-1:0] pwdata,
    output logic [mrms_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output mrms_pkg::cfg_t              cfg
);
    import mrms_pkg::*;

    localparam logic [2:0] REG_RUN_TARGET    = 3'd0;
    localparam logic [2:0] REG_REVERSE       = 3'd1;
    localparam logic [2:0] REG_START_CURRENT = 3'd2;
    localparam logic [2:0] REG_RUN_CURRENT   = 3'd3;
    localparam logic [2:0] REG_DEBUG_CURRENT = 3'd4;
    localparam logic [2:0] REG_RAMP_STEP     = 3'd5;
    localparam logic [2:0] REG_DWELL_TICKS   = 3'd6;
    localparam logic [2:0] REG_TEST_DUTY     = 3'd7;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite;
    assign reg_index = paddr[4:2];
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_target        <= 3'd4;
            cfg_reg.reverse_direction <= 1'b0;
            cfg_reg.start_current     <= 15'd3277;
            cfg_reg.run_current       <= 15'd6554;
            cfg_reg.debug_current     <= 15'd3277;
            cfg_reg.ramp_step         <= 15'd16;
            cfg_reg.dwell_ticks       <= 16'd50;
            cfg_reg.test_duty         <= 16'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_RUN_TARGET:    cfg_reg.run_target        <= pwdata[2:0];
                REG_REVERSE:       cfg_reg.reverse_direction <= pwdata[0];
                REG_START_CURRENT: cfg_reg.start_current     <= pwdata[14:0];
                REG_RUN_CURRENT:   cfg_reg.run_current       <= pwdata[14:0];
                REG_DEBUG_CURRENT: cfg_reg.debug_current     <= pwdata[14:0];
                REG_RAMP_STEP:     cfg_reg.ramp_step         <= pwdata[14:0];
                REG_DWELL_TICKS:   cfg_reg.dwell_ticks       <= pwdata[15:0];
                REG_TEST_DUTY:     cfg_reg.test_duty         <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_RUN_TARGET:    prdata = {29'd0, cfg_reg.run_target};
            REG_REVERSE:       prdata = {31'd0, cfg_reg.reverse_direction};
            REG_START_CURRENT: prdata = {17'd0, cfg_reg.start_current};
            REG_RUN_CURRENT:   prdata = {17'd0, cfg_reg.run_current};
            REG_DEBUG_CURRENT: prdata = {17'd0, cfg_reg.debug_current};
            REG_RAMP_STEP:     prdata = {17'd0, cfg_reg.ramp_step};
            REG_DWELL_TICKS:   prdata = {16'd0, cfg_reg.dwell_ticks};
            REG_TEST_DUTY:     prdata = {16'd0, cfg_reg.test_duty};
            default:           prdata = '0;
        endcase
    end

endmodule

### sv/mrms_ramp.sv
// ----------------------------------------------------------------------------
// Run mode sequencer ramp unit
// Moves a Q15 value one step toward a target, holding inside one step.
// ----------------------------------------------------------------------------
module mrms_ramp (
    input  logic signed [15:0] value,
    input  logic signed [15:0] target,
    input  logic [14:0]        step,
    output logic signed [15:0] ramped
);
    import mrms_pkg::*;

    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic               move;
    logic signed [15:0] step_s;

    assign diff   = 17'(target) - 17'(value);
    assign mag    = diff[16] ? 17'(-diff) : 17'(diff);
    assign move   = mag >= {2'b00, step};
    assign step_s = signed'({1'b0, step});

    // A move only happens when the gap is at least one step, so the sum
    // never passes the target and stays inside the 16-bit range.
    always_comb
    begin
        if (!move)
            ramped = value;
        else if (diff[16])
            ramped = value - step_s;
        else
            ramped = value + step_s;
    end

endmodule

### sv/mrms_core.sv
// ----------------------------------------------------------------------------
// Run mode sequencer core
// Holds the run mode and ramp state and forms the result of one tick.
// ----------------------------------------------------------------------------
module mrms_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  mrms_pkg::tick_t   tick,
    input  mrms_pkg::cfg_t    cfg,
    output mrms_pkg::result_t result_next
);
    import mrms_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_PARAM   = 3'd1,
        ST_PWMTEST = 3'd2,
        ST_DEBUG   = 3'd3,
        ST_OPEN    = 3'd4,
        ST_CURRENT = 3'd5,
        ST_SPEED   = 3'd6,
        ST_FAULT   = 3'd7
    } mode_t;

    localparam logic [2:0] TGT_PWMTEST = 3'd0;
    localparam logic [2:0] TGT_DEBUG   = 3'd1;
    localparam logic [2:0] TGT_OPEN    = 3'd2;
    localparam logic [2:0] TGT_SPEED   = 3'd4;

    mode_t              mode_reg, mode_next;
    logic               enable_reg, enable_next;
    logic               pwm_reg, pwm_next;
    logic signed [15:0] q_ref_reg, q_ref_next;
    logic signed [15:0] q_volt_reg, q_volt_next;
    logic [15:0]        dwell_reg, dwell_next;
    logic signed [15:0] open_tgt_reg, open_tgt_next;
    logic signed [15:0] loop_tgt_reg, loop_tgt_next;

    logic               c_init, s_init, duty;
    logic               en_req;
    logic signed [15:0] ramp_value, ramp_target, ramp_out;
    logic [15:0]        dwell_inc;

    function automatic logic signed [15:0] signed_mag(input logic [14:0] mag,
                                                      input logic rev);
        logic signed [15:0] v;
        v = signed'({1'b0, mag});
        return rev ? -v : v;
    endfunction

    // Open debug ramps the voltage toward the reference; the loop states
    // ramp the reference toward their latched target.
    always_comb
    begin
        if (mode_reg == ST_DEBUG)
        begin
            ramp_value  = q_volt_reg;
            ramp_target = q_ref_reg;
        end
        else
        begin
            ramp_value  = q_ref_reg;
            ramp_target = (mode_reg == ST_OPEN) ? open_tgt_reg : loop_tgt_reg;
        end
    end

    mrms_ramp u_ramp (
        .value  (ramp_value),
        .target (ramp_target),
        .step   (cfg.ramp_step),
        .ramped (ramp_out)
    );

    assign dwell_inc = dwell_reg + 16'd1;

    always_comb
    begin
        // Clear wins over set.
        en_req = enable_reg;
        if (tick.enable_set)
            en_req = 1'b1;
        if (tick.enable_clear)
            en_req = 1'b0;

        enable_next   = en_req;
        mode_next     = mode_reg;
        pwm_next      = pwm_reg;
        q_ref_next    = q_ref_reg;
        q_volt_next   = q_volt_reg;
        dwell_next    = dwell_reg;
        open_tgt_next = open_tgt_reg;
        loop_tgt_next = loop_tgt_reg;
        c_init        = 1'b0;
        s_init        = 1'b0;
        duty          = 1'b0;

        unique case (mode_reg)
            ST_IDLE:
            begin
                if (en_req)
                begin
                    if (cfg.run_target == TGT_PWMTEST)
                    begin
                        pwm_next  = 1'b1;
                        mode_next = ST_PWMTEST;
                    end
                    else
                        mode_next = ST_PARAM;
                end
            end
            ST_PARAM:
            begin
                c_init        = 1'b1;
                dwell_next    = '0;
                open_tgt_next = signed_mag(cfg.start_current, cfg.reverse_direction);
                loop_tgt_next = signed_mag(cfg.run_current, cfg.reverse_direction);
                if (cfg.run_target == TGT_DEBUG)
                begin
                    q_ref_next = signed_mag(cfg.debug_current, cfg.reverse_direction);
                    mode_next  = ST_DEBUG;
                end
                else
                begin
                    q_ref_next = '0;
                    mode_next  = ST_OPEN;
                end
                pwm_next = 1'b1;
            end
            ST_PWMTEST:
                duty = 1'b1;
            ST_DEBUG:
                q_volt_next = ramp_out;
            ST_OPEN:
            begin
                q_ref_next = ramp_out;
                if (tick.open_loop_done && cfg.run_target != TGT_OPEN)
                    mode_next = ST_CURRENT;
            end
            ST_CURRENT:
            begin
                q_ref_next = ramp_out;
                if (cfg.run_target == TGT_SPEED)
                begin
                    dwell_next = dwell_inc;
                    if (dwell_inc > cfg.dwell_ticks)
                    begin
                        dwell_next = '0;
                        s_init     = 1'b1;
                        mode_next  = ST_SPEED;
                    end
                end
            end
            ST_SPEED, ST_FAULT:
                ;
            default:
                ;
        endcase

        if (tick.error_active)
        begin
            pwm_next    = 1'b0;
            enable_next = 1'b0;
            mode_next   = ST_FAULT;
        end
        else if (!en_req)
        begin
            pwm_next  = 1'b0;
            mode_next = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= ST_IDLE;
            enable_reg   <= 1'b0;
            pwm_reg      <= 1'b0;
            q_ref_reg    <= '0;
            q_volt_reg   <= '0;
            dwell_reg    <= '0;
            open_tgt_reg <= '0;
            loop_tgt_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            enable_reg   <= enable_next;
            pwm_reg      <= pwm_next;
            q_ref_reg    <= q_ref_next;
            q_volt_reg   <= q_volt_next;
            dwell_reg    <= dwell_next;
            open_tgt_reg <= open_tgt_next;
            loop_tgt_reg <= loop_tgt_next;
        end
    end

    assign result_next.run_state       = mode_next;
    assign result_next.pwm_on          = pwm_next;
    assign result_next.q_reference     = q_ref_next;
    assign result_next.q_voltage       = q_volt_next;
    assign result_next.controller_init = c_init;
    assign result_next.speed_init      = s_init;
    assign result_next.duty_apply      = duty;

endmodule

### sv/mrms_checker.sv
`include "motor_run_mode_sequencer_unit_defines.svh"
// ----------------------------------------------------------------------------
// Run mode sequencer checker
// Port-level checks on the result channel of the run mode sequencer.
// ----------------------------------------------------------------------------
module mrms_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_stall,
    input mrms_pkg::result_t result
);
    import mrms_pkg::*;

    // A stalled result transfer stays offered and unchanged.
    `MRMS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

    // The power stage is never on while idle or faulted.
    `MRMS_ASSERT_IMP(a_pwm_off_idle, result_valid && (result.run_state == MODE_IDLE || result.run_state == MODE_FAULT), !result.pwm_on)

    // Controller init only comes with the step out of parameter set.
    `MRMS_ASSERT_IMP(a_cinit_mode, result_valid && result.controller_init, result.run_state == MODE_DEBUG || result.run_state == MODE_OPEN || result.run_state == MODE_FAULT || result.run_state == MODE_IDLE)

    // Speed init only comes with entry to speed loop, or an override.
    `MRMS_ASSERT_IMP(a_sinit_mode, result_valid && result.speed_init, result.run_state == MODE_SPEED || result.run_state == MODE_FAULT || result.run_state == MODE_IDLE)

endmodule

bind motor_run_mode_sequencer_unit mrms_checker u_mrms_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

### verif/motor_run_mode_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// Run mode sequencer testbench
// Drives ticks through the run mode sequencer. A short scripted sequence
// is followed by phases of random ticks under changing register settings and
// flow control. Every result transfer is checked against an in-bench model or a typed script row.
// ----------------------------------------------------------------------------
module motor_run_mode_sequencer_unit_tb;

    import mrms_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASES = 12;
    localparam int unsigned TICKS_PER_PHASE = 112;
    localparam int unsigned HOLD_CYCLES = 60;

    // Run target codes written to the run_target register.
    localparam logic [2:0] TGT_PWMTEST = 3'd0;
    localparam logic [2:0] TGT_DEBUG   = 3'd1;
    localparam logic [2:0] TGT_OPEN    = 3'd2;
    localparam logic [2:0] TGT_SPEED   = 3'd4;
    localparam logic [2:0] TGT_BEYOND  = 3'd5;

    // Tick patterns, enable_set in the top bit.
    localparam logic [3:0] T_NONE  = 4'b0000;
    localparam logic [3:0] T_SET   = 4'b1000;
    localparam logic [3:0] T_CLEAR = 4'b0100;
    localparam logic [3:0] T_ERR   = 4'b0010;
    localparam logic [3:0] T_OLD   = 4'b0001;
    localparam logic [3:0] T_ALL   = 4'b1111;

    typedef enum logic [2:0] {
        REG_RUN_TARGET,
        REG_REVERSE,
        REG_START_CURRENT,
        REG_RUN_CURRENT,
        REG_DEBUG_CURRENT,
        REG_RAMP_STEP,
        REG_DWELL_TICKS,
        REG_TEST_DUTY
    } reg_index_e;

    typedef enum int {CFG_HIGH, CFG_LOW, CFG_MIXED} cfg_kind_e;

    typedef struct packed {
        logic       cfg_en;
        reg_index_e cfg_reg;
        logic [31:0] cfg_value;
        tick_t      stim;
        logic       typed;
        result_t    want;
    } script_row_t;

    logic                clk;
    logic                rst_n;
    logic                tick_valid;
    logic                tick_stall;
    tick_t               tick;
    logic                result_valid;
    logic                result_stall;
    result_t             result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Sequencer model state and its copy of the registers.
    cfg_t        seq_cfg;
    logic [2:0]  seq_mode;
    logic        en_latch;
    logic        pwm_flag;
    int          q_ref;
    int          q_volt;
    logic [15:0] dwell_cnt;
    int          open_tgt;
    int          loop_tgt;

    result_t       pending_results[$];
    script_row_t   script[$];
    int unsigned   bad_results;
    int unsigned   results_seen;
    int unsigned   cycle_count;
    int unsigned   idle_pct;
    int unsigned   stall_pct;
    bit            hold_req;

    motor_run_mode_sequencer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic int with_direction(input logic [14:0] mag);
        int v;
        v = int'(mag);
        return seq_cfg.reverse_direction ? -v : v;
    endfunction

    // Moves a Q15 value one ramp step toward its target; a value within one
    // step of the target stays where it is.
    function automatic int ramp_toward(input int value, input int target);
        int amt;
        int gap;
        amt = int'(seq_cfg.ramp_step);
        gap = target - value;
        if (gap < 0)
            gap = -gap;
        if (gap >= amt)
            value = (value < target) ? value + amt : value - amt;
        if (value > 32767)
            value = 32767;
        if (value < -32768)
            value = -32768;
        return value;
    endfunction

    function automatic result_t advance_sequencer(input tick_t t);
        result_t r;
        r = '0;
        if (t.enable_set)
            en_latch = 1'b1;
        if (t.enable_clear)
            en_latch = 1'b0;
        case (seq_mode)
            MODE_IDLE:
            begin
                if (en_latch)
                begin
                    if (seq_cfg.run_target == TGT_PWMTEST)
                    begin
                        pwm_flag = 1'b1;
                        seq_mode = MODE_PWMTEST;
                    end
                    else
                        seq_mode = MODE_PARAM;
                end
            end
            MODE_PARAM:
            begin
                r.controller_init = 1'b1;
                dwell_cnt = '0;
                open_tgt = with_direction(seq_cfg.start_current);
                loop_tgt = with_direction(seq_cfg.run_current);
                if (seq_cfg.run_target == TGT_DEBUG)
                begin
                    q_ref = with_direction(seq_cfg.debug_current);
                    seq_mode = MODE_DEBUG;
                end
                else
                begin
                    q_ref = 0;
                    seq_mode = MODE_OPEN;
                end
                pwm_flag = 1'b1;
            end
            MODE_PWMTEST:
                r.duty_apply = 1'b1;
            MODE_DEBUG:
                q_volt = ramp_toward(q_volt, q_ref);
            MODE_OPEN:
            begin
                q_ref = ramp_toward(q_ref, open_tgt);
                if (t.open_loop_done && seq_cfg.run_target != TGT_OPEN)
                    seq_mode = MODE_CURRENT;
            end
            MODE_CURRENT:
            begin
                q_ref = ramp_toward(q_ref, loop_tgt);
                if (seq_cfg.run_target == TGT_SPEED)
                begin
                    dwell_cnt = dwell_cnt + 16'd1;
                    if (dwell_cnt > seq_cfg.dwell_ticks)
                    begin
                        dwell_cnt = '0;
                        r.speed_init = 1'b1;
                        seq_mode = MODE_SPEED;
                    end
                end
            end
            default:
                ;
        endcase
        if (t.error_active)
        begin
            pwm_flag = 1'b0;
            en_latch = 1'b0;
            seq_mode = MODE_FAULT;
        end
        else if (!en_latch)
        begin
            pwm_flag = 1'b0;
            seq_mode = MODE_IDLE;
        end
        r.run_state = seq_mode;
        r.pwm_on = pwm_flag;
        r.q_reference = q_ref[15:0];
        r.q_voltage = q_volt[15:0];
        return r;
    endfunction

    task automatic write_reg(input reg_index_e idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_RUN_TARGET:    seq_cfg.run_target = value[2:0];
            REG_REVERSE:       seq_cfg.reverse_direction = value[0];
            REG_START_CURRENT: seq_cfg.start_current = value[14:0];
            REG_RUN_CURRENT:   seq_cfg.run_current = value[14:0];
            REG_DEBUG_CURRENT: seq_cfg.debug_current = value[14:0];
            REG_RAMP_STEP:     seq_cfg.ramp_step = value[14:0];
            REG_DWELL_TICKS:   seq_cfg.dwell_ticks = value[15:0];
            REG_TEST_DUTY:     seq_cfg.test_duty = value[15:0];
            default:           ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offers one tick, leaving valid high after the transfer so that a
    // following tick can go out without a gap.
    task automatic send_tick(input tick_t t, input logic typed, input result_t want);
        result_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            tick_valid <= 1'b0;
        end
        @(negedge clk);
        tick_valid <= 1'b1;
        tick <= t;
        do @(posedge clk); while (tick_stall);
        predicted = advance_sequencer(t);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        @(negedge clk);
        tick_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic cfg_en, input reg_index_e cfg_reg,
                           input logic [31:0] cfg_value, input logic [3:0] stim,
                           input logic typed, input logic [2:0] mode,
                           input logic pwm, input logic cinit);
        script_row_t row;
        row = '0;
        row.cfg_en = cfg_en;
        row.cfg_reg = cfg_reg;
        row.cfg_value = cfg_value;
        row.stim = tick_t'(stim);
        row.typed = typed;
        row.want.run_state = mode;
        row.want.pwm_on = pwm;
        row.want.controller_init = cinit;
        script.push_back(row);
    endtask

    function automatic logic [31:0] draw(input int unsigned hi, input cfg_kind_e kind);
        if (kind == CFG_HIGH)
            return hi;
        if (kind == CFG_LOW)
            return 0;
        case ($urandom_range(5))
            0:       return 0;
            1:       return hi;
            default: return $urandom_range(hi);
        endcase
    endfunction

    task automatic set_phase_config(input cfg_kind_e kind);
        logic [31:0] ramp_amt;
        logic [31:0] dwell;
        logic [31:0] target;
        target = draw(TGT_SPEED, kind);
        if (kind == CFG_MIXED && $urandom_range(7) == 0)
            target = $urandom_range(7, 5);
        if (kind == CFG_HIGH)
        begin
            ramp_amt = 32767;
            dwell = 65534;
        end
        else if (kind == CFG_LOW)
        begin
            ramp_amt = 1;
            dwell = 0;
        end
        else
        begin
            case ($urandom_range(9))
                0:       ramp_amt = 0;
                1:       ramp_amt = 32767;
                2:       ramp_amt = 1;
                default: ramp_amt = $urandom_range(3000, 50);
            endcase
            case ($urandom_range(9))
                0:       dwell = 65535;
                1:       dwell = 65534;
                2:       dwell = 0;
                default: dwell = $urandom_range(40, 1);
            endcase
        end
        write_reg(REG_RUN_TARGET, target);
        write_reg(REG_REVERSE, draw(1, kind));
        write_reg(REG_START_CURRENT, draw(32767, kind));
        write_reg(REG_RUN_CURRENT, draw(32767, kind));
        write_reg(REG_DEBUG_CURRENT, draw(32767, kind));
        write_reg(REG_RAMP_STEP, ramp_amt);
        write_reg(REG_DWELL_TICKS, dwell);
        write_reg(REG_TEST_DUTY, draw(65535, kind));
    endtask

    // Result side: random stall, plus one long hold-off so that both
    // internal registers fill and the tick side stalls.
    initial
    begin
        int unsigned hold_left;
        bit hold_started;
        hold_left = 0;
        hold_started = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_started)
            begin
                hold_started = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                if (bad_results < 10)
                    $display("result transfer %0d arrived with no tick pending", results_seen);
                bad_results++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.run_state !== want.run_state || result.pwm_on !== want.pwm_on
                    || result.q_reference !== want.q_reference
                    || result.q_voltage !== want.q_voltage
                    || result.controller_init !== want.controller_init
                    || result.speed_init !== want.speed_init
                    || result.duty_apply !== want.duty_apply)
                begin
                    if (bad_results < 10)
                        $display({"result %0d: expected mode %0d pwm %0d qref %0d qvolt %0d ",
                                  "pulses %b%b%b, got mode %0d pwm %0d qref %0d qvolt %0d ",
                                  "pulses %b%b%b"}, results_seen,
                                 want.run_state, want.pwm_on, want.q_reference,
                                 want.q_voltage, want.controller_init, want.speed_init,
                                 want.duty_apply, result.run_state, result.pwm_on,
                                 result.q_reference, result.q_voltage,
                                 result.controller_init, result.speed_init,
                                 result.duty_apply);
                    bad_results++;
                end
            end
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned sent;
        int unsigned length;
        int unsigned k;
        bit wellformed;
        tick_t t;
        cfg_kind_e kind;

        rst_n = 1'b0;
        tick_valid = 1'b0;
        tick = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b0;
        bad_results = 0;
        results_seen = 0;

        seq_cfg.run_target = TGT_SPEED;
        seq_cfg.reverse_direction = 1'b0;
        seq_cfg.start_current = 15'd3277;
        seq_cfg.run_current = 15'd6554;
        seq_cfg.debug_current = 15'd3277;
        seq_cfg.ramp_step = 15'd16;
        seq_cfg.dwell_ticks = 16'd50;
        seq_cfg.test_duty = 16'd0;
        seq_mode = MODE_IDLE;
        en_latch = 1'b0;
        pwm_flag = 1'b0;
        q_ref = 0;
        q_volt = 0;
        dwell_cnt = '0;
        open_tgt = 0;
        loop_tgt = 0;

        // Reset defaults first: clear beats set, error forces fault, a tick
        // with the latch cleared returns to idle, then the open and current loops.
        add_row(0, REG_RUN_TARGET, 0, T_NONE, 1, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_ALL, 1, MODE_FAULT, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_NONE, 1, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_SET, 1, MODE_PARAM, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_NONE, 1, MODE_OPEN, 1, 1);
        add_row(0, REG_RUN_TARGET, 0, T_NONE, 0, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_OLD, 0, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_ERR, 0, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_SET, 0, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_CLEAR, 0, MODE_IDLE, 0, 0);
        // Zero dwell: speed loop on the first current loop tick.
        add_row(1, REG_DWELL_TICKS, 0, T_SET, 0, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_NONE, 0, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_OLD, 0, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_NONE, 0, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_NONE, 0, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_CLEAR, 0, MODE_IDLE, 0, 0);
        // PWM test, and a duty pulse still reported on the disabling tick.
        add_row(1, REG_RUN_TARGET, TGT_PWMTEST, T_SET, 0, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_NONE, 0, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_CLEAR, 0, MODE_IDLE, 0, 0);
        // Open debug with a step larger than the distance to the target.
        add_row(1, REG_RUN_TARGET, TGT_DEBUG, T_SET, 0, MODE_IDLE, 0, 0);
        add_row(1, REG_RAMP_STEP, 32767, T_NONE, 0, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_NONE, 0, MODE_IDLE, 0, 0);
        // Run target outside the named choices.
        add_row(1, REG_RUN_TARGET, TGT_BEYOND, T_CLEAR, 0, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_SET, 0, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_NONE, 0, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_OLD, 0, MODE_IDLE, 0, 0);
        add_row(0, REG_RUN_TARGET, 0, T_NONE, 0, MODE_IDLE, 0, 0);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].cfg_en)
            begin
                drain_results();
                write_reg(script[i].cfg_reg, script[i].cfg_value);
            end
            send_tick(script[i].stim, script[i].typed, script[i].want);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            if (phase == 0)
                kind = CFG_HIGH;
            else if (phase == 1)
                kind = CFG_LOW;
            else
                kind = CFG_MIXED;
            set_phase_config(kind);
            case (phase % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 78;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 78;
                end
                default:
                begin
                    idle_pct = 16;
                    stall_pct = 16;
                end
            endcase
            sent = 0;
            while (sent < TICKS_PER_PHASE)
            begin
                // Most runs clear any fault, enable and then stay error free
                // long enough to reach the loops; the rest are raw noise.
                length = $urandom_range(120, 4);
                wellformed = ($urandom_range(99) < 80);
                for (k = 0; k < length && sent < TICKS_PER_PHASE; k++)
                begin
                    if (!wellformed)
                        t = tick_t'(4'($urandom));
                    else if (k == 0)
                        t = tick_t'(T_CLEAR);
                    else if (k == 1)
                        t = tick_t'(T_SET);
                    else
                    begin
                        t = tick_t'(T_NONE);
                        t.enable_set = 1'($urandom_range(1));
                        t.open_loop_done = ($urandom_range(7) == 0);
                        if (k == length - 1)
                        begin
                            case ($urandom_range(3))
                                0:       t.error_active = 1'b1;
                                1:       t.enable_clear = 1'b1;
                                default: ;
                            endcase
                        end
                    end
                    if (phase == 4 && sent == 20)
                        hold_req = 1'b1;
                    send_tick(t, 1'b0, '0);
                    sent++;
                end
            end
        end

        drain_results();
        repeat (6) @(posedge clk);
        if (bad_results == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
